// ===== rtl/nmfm_pkg.sv =====
// nmfm_pkg: shared types, constants and micro-program for the mach-from-mass solver
`default_nettype none

package nmfm_pkg;

  // fixed field widths
  localparam int unsigned OUT_W     = 48;
  localparam int unsigned MS_W      = 47;
  localparam int unsigned TOL_W     = 25;
  localparam int unsigned IT_W      = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PC_W      = 6;
  localparam int unsigned RF_DEPTH  = 16;
  localparam int unsigned RF_IDX_W  = 4;

  // register reset values
  localparam logic [MS_W-1:0]  RST_MASS_SCALE = 47'd16777216;
  localparam logic [IT_W-1:0]  RST_MAX_ITER   = 8'd99;
  localparam logic [TOL_W-1:0] RST_TOL        = 25'd17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASS_SCALE = 3'd0,
    CFG_MAX_ITER   = 3'd1,
    CFG_REL_TOL    = 3'd2,
    CFG_ABS_TOL    = 3'd3,
    CFG_SMALL_OFF  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_CONVERGED = 2'd0,
    STAT_LIMIT     = 2'd1,
    STAT_ZERO_DIV  = 2'd2
  } status_e;

  // micro-operations: datapath ops first, then sequencer ops
  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_ABS    = 4'd4,
    OP_SELZ   = 4'd5,
    OP_LTSET  = 4'd6,
    OP_LTAND  = 4'd7,
    OP_CLRDZ  = 4'd8,
    OP_LOOP   = 4'd9,
    OP_DZCOND = 4'd10,
    OP_CONV   = 4'd11,
    OP_JMP    = 4'd12,
    OP_FIN    = 4'd13
  } op_e;

  // operand sources: msb clear selects a working register
  typedef enum logic [4:0] {
    S_X0   = 5'd0,
    S_Y0   = 5'd1,
    S_X1   = 5'd2,
    S_Y1   = 5'd3,
    S_DF   = 5'd4,
    S_DP   = 5'd5,
    S_T0   = 5'd6,
    S_T1   = 5'd7,
    S_T2   = 5'd8,
    S_T3   = 5'd9,
    S_T4   = 5'd10,
    S_T5   = 5'd11,
    S_C0   = 5'd16,
    S_C1   = 5'd17,
    S_C2   = 5'd18,
    S_C3   = 5'd19,
    S_C4   = 5'd20,
    S_C5   = 5'd21,
    S_M    = 5'd22,
    S_MS   = 5'd23,
    S_RTOL = 5'd24,
    S_ATOL = 5'd25,
    S_SOFF = 5'd26
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e dst;
    src_e sa;
    src_e sb;
  } instr_t;

  typedef struct packed {
    logic start;
    logic load;
    op_e  op;
    src_e dst;
    src_e sa;
    src_e sb;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic dz;
    logic cmp;
  } dp_stat_t;

  typedef struct packed {
    logic            load;
    status_e         status;
    logic [IT_W-1:0] iters;
  } out_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_WAIT  = 2'd2,
    ST_DONE  = 2'd3
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_RUN   = 2'd2
  } dp_phase_e;

  localparam logic [PC_W-1:0] PC_LOOP = 6'd11;
  localparam logic [PC_W-1:0] PC_FIN  = 6'd52;

  function automatic instr_t mk(input op_e o, input src_e d, input src_e a, input src_e b);
    instr_t r;
    r.op  = o;
    r.dst = d;
    r.sa  = a;
    r.sb  = b;
    return r;
  endfunction

  // solver program: start value, residual, then the newton pass loop
  function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
    instr_t r;
    r = mk(OP_FIN, S_X0, S_C0, S_C0);
    unique case (pc)
      6'd0:  r = mk(OP_CLRDZ, S_X0, S_C0, S_C0);
      6'd1:  r = mk(OP_ADD,   S_X0, S_C1, S_C0);
      // residual at the start value
      6'd2:  r = mk(OP_MUL,   S_T0, S_X0, S_X0);
      6'd3:  r = mk(OP_MUL,   S_T1, S_T0, S_X0);
      6'd4:  r = mk(OP_ADD,   S_T2, S_C1, S_T0);
      6'd5:  r = mk(OP_MUL,   S_T3, S_T1, S_T2);
      6'd6:  r = mk(OP_MUL,   S_T3, S_MS, S_T3);
      6'd7:  r = mk(OP_ADD,   S_T4, S_C1, S_X0);
      6'd8:  r = mk(OP_DIV,   S_T5, S_T3, S_T4);
      6'd9:  r = mk(OP_SUB,   S_Y0, S_T5, S_M);
      6'd10: r = mk(OP_SELZ,  S_Y0, S_Y0, S_C0);
      // pass head
      6'd11: r = mk(OP_LOOP,  S_X0, S_C0, S_C0);
      6'd12: r = mk(OP_CLRDZ, S_X0, S_C0, S_C0);
      // slope
      6'd13: r = mk(OP_MUL,   S_T0, S_X0, S_X0);
      6'd14: r = mk(OP_MUL,   S_T1, S_C4, S_X0);
      6'd15: r = mk(OP_ADD,   S_T1, S_C5, S_T1);
      6'd16: r = mk(OP_MUL,   S_T1, S_X0, S_T1);
      6'd17: r = mk(OP_ADD,   S_T1, S_C2, S_T1);
      6'd18: r = mk(OP_MUL,   S_T1, S_X0, S_T1);
      6'd19: r = mk(OP_ADD,   S_T1, S_C3, S_T1);
      6'd20: r = mk(OP_MUL,   S_T1, S_T0, S_T1);
      6'd21: r = mk(OP_MUL,   S_T1, S_MS, S_T1);
      6'd22: r = mk(OP_ADD,   S_T2, S_C1, S_X0);
      6'd23: r = mk(OP_MUL,   S_T2, S_T2, S_T2);
      6'd24: r = mk(OP_DIV,   S_DF, S_T1, S_T2);
      // step
      6'd25: r = mk(OP_CLRDZ, S_X0, S_C0, S_C0);
      6'd26: r = mk(OP_DIV,   S_DP, S_Y0, S_DF);
      6'd27: r = mk(OP_DZCOND, S_X0, S_C0, S_C0);
      6'd28: r = mk(OP_CLRDZ, S_X0, S_C0, S_C0);
      6'd29: r = mk(OP_SUB,   S_X1, S_X0, S_DP);
      // residual at the new iterate
      6'd30: r = mk(OP_MUL,   S_T0, S_X1, S_X1);
      6'd31: r = mk(OP_MUL,   S_T1, S_T0, S_X1);
      6'd32: r = mk(OP_ADD,   S_T2, S_C1, S_T0);
      6'd33: r = mk(OP_MUL,   S_T3, S_T1, S_T2);
      6'd34: r = mk(OP_MUL,   S_T3, S_MS, S_T3);
      6'd35: r = mk(OP_ADD,   S_T4, S_C1, S_X1);
      6'd36: r = mk(OP_DIV,   S_T5, S_T3, S_T4);
      6'd37: r = mk(OP_SUB,   S_Y1, S_T5, S_M);
      6'd38: r = mk(OP_DZCOND, S_X0, S_C0, S_C0);
      6'd39: r = mk(OP_SELZ,  S_Y1, S_Y1, S_C0);
      // convergence test
      6'd40: r = mk(OP_ABS,   S_T0, S_DP, S_C0);
      6'd41: r = mk(OP_ADD,   S_T0, S_T0, S_T0);
      6'd42: r = mk(OP_ABS,   S_T1, S_X1, S_C0);
      6'd43: r = mk(OP_ADD,   S_T1, S_T1, S_SOFF);
      6'd44: r = mk(OP_MUL,   S_T1, S_RTOL, S_T1);
      6'd45: r = mk(OP_LTSET, S_X0, S_T0, S_T1);
      6'd46: r = mk(OP_ABS,   S_T2, S_Y1, S_C0);
      6'd47: r = mk(OP_LTAND, S_X0, S_T2, S_ATOL);
      6'd48: r = mk(OP_CONV,  S_X0, S_C0, S_C0);
      6'd49: r = mk(OP_ADD,   S_X0, S_X1, S_C0);
      6'd50: r = mk(OP_ADD,   S_Y0, S_Y1, S_C0);
      6'd51: r = mk(OP_JMP,   S_X0, S_C0, S_C0);
      default: r = mk(OP_FIN, S_X0, S_C0, S_C0);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nmfm_dpath.sv =====
// nmfm_dpath: sign-magnitude working registers, saturating add, digit-serial multiply, divider
`default_nettype none

module nmfm_dpath import nmfm_pkg::*; #(
  parameter int unsigned WORD_BITS = 48,
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dp_cmd_t                 cmd_i,
  input  wire logic signed [OUT_W-1:0] target_mass_i,
  input  wire logic [MS_W-1:0]         mass_scale_i,
  input  wire logic [TOL_W-1:0]        rel_tol_i,
  input  wire logic [TOL_W-1:0]        abs_tol_i,
  input  wire logic [TOL_W-1:0]        small_off_i,
  output dp_stat_t                     stat_o,
  output logic signed [OUT_W-1:0]      root_value_o
);

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned VW  = W + 1;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned DIG = 16;
  localparam int unsigned ND  = (W + DIG - 1) / DIG;
  localparam int unsigned MBW = ND * DIG;
  localparam int unsigned AW  = W + MBW;
  localparam int unsigned QW  = W + F;
  localparam int unsigned CW  = $clog2(QW) + 1;
  localparam int unsigned XW  = ((W > OUT_W) ? W : OUT_W) + 1;

  localparam logic [W-1:0]  MAXPOS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINMAG = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] ONE_FX = PW'(1) << F;
  localparam logic [XW-1:0] OUT_NEG_LIM = XW'(1) << (OUT_W - 1);
  localparam logic [XW-1:0] OUT_POS_LIM = OUT_NEG_LIM - XW'(1);

  // saturate a magnitude into the word, zero is always positive
  function automatic logic [VW-1:0] sat(input logic neg, input logic [PW-1:0] m);
    logic [PW-1:0] lim;
    logic [W-1:0]  r;
    lim = neg ? PW'(MINMAG) : PW'(MAXPOS);
    r   = (m > lim) ? lim[W-1:0] : m[W-1:0];
    return {neg && (r != '0), r};
  endfunction

  function automatic logic [VW-1:0] fadd(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW-1:0] r;
    if (a[W] == b[W]) begin
      r = sat(a[W], PW'(a[W-1:0]) + PW'(b[W-1:0]));
    end else if (a[W-1:0] >= b[W-1:0]) begin
      r = sat(a[W], PW'(a[W-1:0] - b[W-1:0]));
    end else begin
      r = sat(b[W], PW'(b[W-1:0] - a[W-1:0]));
    end
    return r;
  endfunction

  function automatic logic flt(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic r;
    if (a[W] != b[W]) begin
      r = a[W];
    end else if (a[W]) begin
      r = a[W-1:0] > b[W-1:0];
    end else begin
      r = a[W-1:0] < b[W-1:0];
    end
    return r;
  endfunction

  // read-only sources: constants, input and registers
  function automatic logic [VW-1:0] cval(input src_e s, input logic [VW-1:0] m,
                                         input logic [MS_W-1:0] ms, input logic [TOL_W-1:0] rt,
                                         input logic [TOL_W-1:0] at, input logic [TOL_W-1:0] so);
    logic [VW-1:0] r;
    unique case (s)
      S_C1:    r = sat(1'b0, ONE_FX);
      S_C2:    r = sat(1'b0, PW'(2) << F);
      S_C3:    r = sat(1'b0, PW'(3) << F);
      S_C4:    r = sat(1'b0, PW'(4) << F);
      S_C5:    r = sat(1'b0, PW'(5) << F);
      S_M:     r = m;
      S_MS:    r = sat(1'b0, PW'(ms));
      S_RTOL:  r = sat(1'b0, PW'(rt));
      S_ATOL:  r = sat(1'b0, PW'(at));
      S_SOFF:  r = sat(1'b0, PW'(so));
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [VW-1:0]  rf_q [RF_DEPTH];
  logic [VW-1:0]  m_q, opa_q, opb_q, x_last_q;
  op_e            op_q;
  src_e           dst_q;
  dp_phase_e      phase_q, phase_d;
  logic [CW-1:0]  cnt_q;
  logic           dz_q, dz_d, cmp_q, cmp_d;
  logic [AW-1:0]  acc_q, acc_next, acc_sh;
  logic [MBW-1:0] mbs_q;
  logic [W-1:0]   rem_q, rem_next;
  logic [QW-1:0]  quo_q, quo_next;
  logic [W:0]     rem_sh, rem_diff;
  logic           rem_ge;
  logic [W+DIG-1:0] pp;
  logic           wr_en, done;
  logic [VW-1:0]  wr_data, m_in;
  logic [OUT_W-1:0] t_mag;
  logic           res_neg;

  // input mass into sign-magnitude
  always_comb begin
    t_mag = target_mass_i[OUT_W-1] ? (OUT_W'(0) - target_mass_i) : target_mass_i;
    m_in  = sat(target_mass_i[OUT_W-1], PW'(t_mag));
  end

  // multiply and divide steps
  always_comb begin
    pp       = opa_q[W-1:0] * mbs_q[MBW-1 -: DIG];
    acc_next = (acc_q << DIG) + AW'(pp);
    acc_sh   = acc_next >> F;
    rem_sh   = {rem_q, quo_q[QW-1]};
    rem_ge   = rem_sh >= {1'b0, opb_q[W-1:0]};
    rem_diff = rem_sh - {1'b0, opb_q[W-1:0]};
    rem_next = rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
    quo_next = {quo_q[QW-2:0], rem_ge};
    res_neg  = opa_q[W] ^ opb_q[W];
  end

  // phase control and write-back selection
  always_comb begin
    phase_d = phase_q;
    wr_en   = 1'b0;
    wr_data = '0;
    done    = 1'b0;
    dz_d    = dz_q;
    cmp_d   = cmp_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (cmd_i.start) phase_d = PH_SETUP;
      end
      PH_SETUP: begin
        done = 1'b1;
        unique case (op_q)
          OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = fadd(opa_q, opb_q);
          end
          OP_SUB: begin
            wr_en   = 1'b1;
            wr_data = fadd(opa_q, sat(!opb_q[W], PW'(opb_q[W-1:0])));
          end
          OP_ABS: begin
            wr_en   = 1'b1;
            wr_data = sat(1'b0, PW'(opa_q[W-1:0]));
          end
          OP_SELZ: begin
            wr_en   = 1'b1;
            wr_data = dz_q ? '0 : opa_q;
          end
          OP_LTSET: cmp_d = flt(opa_q, opb_q);
          OP_LTAND: cmp_d = cmp_q & flt(opa_q, opb_q);
          OP_CLRDZ: dz_d = 1'b0;
          OP_MUL:   done = 1'b0;
          OP_DIV: begin
            if (opb_q[W-1:0] == '0) begin
              wr_en = 1'b1;
              dz_d  = 1'b1;
            end else begin
              done = 1'b0;
            end
          end
          default: ;
        endcase
        phase_d = done ? PH_IDLE : PH_RUN;
      end
      PH_RUN: begin
        if (op_q == OP_MUL) begin
          if (cnt_q == CW'(ND - 1)) begin
            done    = 1'b1;
            wr_en   = 1'b1;
            wr_data = sat(res_neg, acc_sh[PW-1:0]);
          end
        end else if (cnt_q == CW'(QW - 1)) begin
          done    = 1'b1;
          wr_en   = 1'b1;
          wr_data = sat(res_neg, PW'(quo_next));
        end
        if (done) phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      dz_q    <= 1'b0;
      cmp_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      dz_q    <= dz_d;
      cmp_q   <= cmp_d;
      if (phase_q == PH_RUN) cnt_q <= cnt_q + CW'(1);
      else                   cnt_q <= '0;
    end
  end

  // working registers, operand reads and iteration payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) m_q <= m_in;
    if (cmd_i.start) begin
      op_q  <= cmd_i.op;
      dst_q <= cmd_i.dst;
      opa_q <= cmd_i.sa[4] ? cval(cmd_i.sa, m_q, mass_scale_i, rel_tol_i, abs_tol_i, small_off_i)
                           : rf_q[cmd_i.sa[RF_IDX_W-1:0]];
      opb_q <= cmd_i.sb[4] ? cval(cmd_i.sb, m_q, mass_scale_i, rel_tol_i, abs_tol_i, small_off_i)
                           : rf_q[cmd_i.sb[RF_IDX_W-1:0]];
    end
    if (wr_en) rf_q[dst_q[RF_IDX_W-1:0]] <= wr_data;
    if (wr_en && dst_q == S_X0) x_last_q <= wr_data;
    if (phase_q == PH_SETUP) begin
      acc_q <= '0;
      mbs_q <= MBW'(opb_q[W-1:0]);
      rem_q <= '0;
      quo_q <= {opa_q[W-1:0], {F{1'b0}}};
    end else if (phase_q == PH_RUN) begin
      acc_q <= acc_next;
      mbs_q <= mbs_q << DIG;
      rem_q <= rem_next;
      quo_q <= quo_next;
    end
  end

  // last iterate clipped to the output field
  always_comb begin
    logic [XW-1:0] xm;
    xm = XW'(x_last_q[W-1:0]);
    if (x_last_q[W]) begin
      if (xm > OUT_NEG_LIM) xm = OUT_NEG_LIM;
      root_value_o = OUT_W'(0) - xm[OUT_W-1:0];
    end else begin
      if (xm > OUT_POS_LIM) xm = OUT_POS_LIM;
      root_value_o = xm[OUT_W-1:0];
    end
  end

  assign stat_o.done = done;
  assign stat_o.dz   = dz_q;
  assign stat_o.cmp  = cmp_q;

  // a new operation only starts on an idle unit
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.start |-> phase_q == PH_IDLE)
    else $error("operation started while unit busy");

  // only multiply and divide iterate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   phase_q == PH_RUN |-> (op_q == OP_MUL || op_q == OP_DIV))
    else $error("iteration phase for single-cycle op");

  // divider count stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   phase_q == PH_RUN |-> cnt_q < CW'(QW))
    else $error("step counter overran");

endmodule

`default_nettype wire

// ===== rtl/nmfm_ctrl.sv =====
// nmfm_ctrl: micro-program sequencer with pass counter and solve status
`default_nettype none

module nmfm_ctrl import nmfm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [IT_W-1:0] max_iter_i,
  input  wire logic            out_free_i,
  input  wire dp_stat_t        dp_stat_i,
  output dp_cmd_t              dp_cmd_o,
  output out_ctl_t             out_ctl_o
);

  ctrl_state_e     state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [IT_W-1:0] k_q, k_d;
  status_e         cond_q, cond_d;
  instr_t          ins;

  assign ins = prog_rom(pc_q);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      k_q     <= '0;
      cond_q  <= STAT_LIMIT;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      k_q     <= k_d;
      cond_q  <= cond_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    pc_d           = pc_q;
    k_d            = k_q;
    cond_d         = cond_q;
    dp_cmd_o.start = 1'b0;
    dp_cmd_o.load  = 1'b0;
    dp_cmd_o.op    = ins.op;
    dp_cmd_o.dst   = ins.dst;
    dp_cmd_o.sa    = ins.sa;
    dp_cmd_o.sb    = ins.sb;
    out_ctl_o.load   = 1'b0;
    out_ctl_o.status = cond_q;
    out_ctl_o.iters  = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.load = 1'b1;
          pc_d    = '0;
          k_d     = '0;
          cond_d  = STAT_LIMIT;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        unique case (ins.op)
          OP_LOOP: begin
            if (cond_q != STAT_LIMIT || k_q >= max_iter_i) begin
              pc_d = PC_FIN;
            end else begin
              k_d  = k_q + IT_W'(1);
              pc_d = pc_q + PC_W'(1);
            end
          end
          OP_DZCOND: begin
            if (dp_stat_i.dz) cond_d = STAT_ZERO_DIV;
            pc_d = pc_q + PC_W'(1);
          end
          OP_CONV: begin
            if (dp_stat_i.cmp && cond_q != STAT_ZERO_DIV) cond_d = STAT_CONVERGED;
            pc_d = pc_q + PC_W'(1);
          end
          OP_JMP: pc_d = PC_LOOP;
          OP_FIN: state_d = ST_DONE;
          default: begin
            dp_cmd_o.start = 1'b1;
            state_d        = ST_WAIT;
          end
        endcase
      end
      ST_WAIT: begin
        if (dp_stat_i.done) begin
          pc_d    = pc_q + PC_W'(1);
          state_d = ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_ctl_o.load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = state_q != ST_IDLE;

  // datapath only finishes what was issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   dp_stat_i.done |-> state_q == ST_WAIT)
    else $error("datapath done without a pending op");

  // end of program always hands over a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_ISSUE && ins.op == OP_FIN) |=> state_q == ST_DONE)
    else $error("program end did not reach result state");

  // no new command while the result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == ST_DONE |-> !dp_cmd_o.start && !dp_cmd_o.load)
    else $error("command issued while holding result");

endmodule

`default_nettype wire

// ===== rtl/newton_mach_from_mass.sv =====
// newton_mach_from_mass: top level with configuration registers and result register
//
//  channel  direction  handshake                 payload
//  in       request    in_valid_i / in_stall_o   target_mass_i
//  out      result     out_valid_o / out_stall_i root_value_o, solve_status_o, iterations_used_o
//  cfg      write      cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  the solve at Q24.24 runs on the shared restoring divider (three per pass) and the
//  16-bit digit multiplier (twelve per pass), both driven by the sequencer.
//  one request is solved at a time; a new one is taken while the result register waits.
//  reset clears control state and loads configuration reset values, no clearing pass.
//  a stalled result holds in its register; the solver idles until it can hand over.
`default_nettype none

module newton_mach_from_mass import nmfm_pkg::*; #(
  parameter int unsigned WORD_BITS = 48,
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic signed [OUT_W-1:0] target_mass_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [OUT_W-1:0]      root_value_o,
  output logic [1:0]                   solve_status_o,
  output logic [IT_W-1:0]              iterations_used_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [MS_W-1:0]         cfg_data_i
);

  logic [MS_W-1:0]  mass_scale_q;
  logic [IT_W-1:0]  max_iter_q;
  logic [TOL_W-1:0] rel_tol_q, abs_tol_q, small_off_q;
  logic             out_valid_q, out_free;
  logic signed [OUT_W-1:0] root_value_q, root_dp;
  logic [1:0]       status_q;
  logic [IT_W-1:0]  iters_q;
  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  out_ctl_t         out_ctl;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_scale_q <= RST_MASS_SCALE;
      max_iter_q   <= RST_MAX_ITER;
      rel_tol_q    <= RST_TOL;
      abs_tol_q    <= RST_TOL;
      small_off_q  <= RST_TOL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MASS_SCALE: mass_scale_q <= cfg_data_i;
        CFG_MAX_ITER:   max_iter_q   <= cfg_data_i[IT_W-1:0];
        CFG_REL_TOL:    rel_tol_q    <= cfg_data_i[TOL_W-1:0];
        CFG_ABS_TOL:    abs_tol_q    <= cfg_data_i[TOL_W-1:0];
        CFG_SMALL_OFF:  small_off_q  <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // result register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ctl.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ctl.load) begin
      root_value_q <= root_dp;
      status_q     <= out_ctl.status;
      iters_q      <= out_ctl.iters;
    end
  end

  nmfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .max_iter_i (max_iter_q),
    .out_free_i (out_free),
    .dp_stat_i  (dp_stat),
    .dp_cmd_o   (dp_cmd),
    .out_ctl_o  (out_ctl)
  );

  nmfm_dpath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .target_mass_i (target_mass_i),
    .mass_scale_i  (mass_scale_q),
    .rel_tol_i     (rel_tol_q),
    .abs_tol_i     (abs_tol_q),
    .small_off_i   (small_off_q),
    .stat_o        (dp_stat),
    .root_value_o  (root_dp)
  );

  assign out_valid_o       = out_valid_q;
  assign root_value_o      = root_value_q;
  assign solve_status_o    = status_q;
  assign iterations_used_o = iters_q;

endmodule

`default_nettype wire
